/* design/fault_qualifier_bank_macros.svh */
// Assertion macros used by the fault qualifier bank design file
`ifndef FAULT_QUALIFIER_BANK_MACROS_SVH
`define FAULT_QUALIFIER_BANK_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FQB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FQB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/fqb_pkg.sv */
// Shared constants, codes and types of the fault qualifier bank
package fqb_pkg;

	localparam int FAULT_COUNT = 32;
	localparam int TICK_MS     = 10;
	localparam int COUNT_BITS  = 16;

	localparam int MASK_W  = 32;
	localparam int CH_W    = 5;
	localparam int OP_W    = 2;
	localparam int TH_W    = 16;
	localparam int PER_W   = 8;
	localparam int CRIT_W  = 2;
	localparam int MAP_W   = 2 * MASK_W;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 64;

	typedef enum logic [OP_W-1:0] {
		OP_TICK,
		OP_LOAD,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		REG_ENABLE,
		REG_OVERRIDE,
		REG_CRIT
	} reg_idx_t;

	localparam logic [CRIT_W-1:0] CRIT_WARNING  = 2'd1;
	localparam logic [CRIT_W-1:0] CRIT_ERROR    = 2'd2;
	localparam logic [CRIT_W-1:0] CRIT_CRITICAL = 2'd3;

	typedef struct packed {
		logic [TH_W-1:0]  rise_ticks;
		logic [TH_W-1:0]  rise_signals;
		logic [TH_W-1:0]  fall_ticks;
		logic [PER_W-1:0] period_ms;
	} thr_entry_t;

endpackage

/* design/fqb_ifs.sv */
// Request and result channel interfaces of the fault qualifier bank
interface fqb_req_if import fqb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [MASK_W-1:0] signal_mask;
	logic [CH_W-1:0]   entry_index;
	logic [TH_W-1:0]   rise_ticks;
	logic [TH_W-1:0]   rise_signals;
	logic [TH_W-1:0]   fall_ticks;
	logic [PER_W-1:0]  period_ms;

	modport source (
		output valid, operation, signal_mask, entry_index,
		       rise_ticks, rise_signals, fall_ticks, period_ms,
		input  ready
	);
	modport sink (
		input  valid, operation, signal_mask, entry_index,
		       rise_ticks, rise_signals, fall_ticks, period_ms,
		output ready
	);
endinterface

interface fqb_rsp_if import fqb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] active_mask;
	logic [MASK_W-1:0] history_mask;
	logic [MASK_W-1:0] rose_mask;
	logic [MASK_W-1:0] fell_mask;
	logic              warning_event;
	logic              error_event;
	logic              critical_event;

	modport source (
		output valid, active_mask, history_mask, rose_mask, fell_mask,
		       warning_event, error_event, critical_event,
		input  ready
	);
	modport sink (
		input  valid, active_mask, history_mask, rose_mask, fell_mask,
		       warning_event, error_event, critical_event,
		output ready
	);
endinterface

/* design/fault_qualifier_bank.sv */
// Fault qualifier bank: walks every fault channel per tick request
//
//  channel | direction | handshake           | payload
//  req     | in        | valid / ready       | operation, signal mask, threshold entry
//  rsp     | out       | valid / ready       | masks and criticality events
//  apb     | in        | psel/penable/pready | enable, override, criticality map
//
// A tick request walks every channel in the walk state, then passes through the done state
// into rsp.valid, and the next request is taken once the sequencer is back in idle: one channel
// enters the three-stage read/compute/write-back loop per cycle, set by the single read port of
// the threshold and counter memories. Load and clear requests skip the walk and go from idle
// straight to the done state, which then raises rsp.valid.
// req.ready is high only in idle; a finished result waits in the rsp register, and the next
// result waits in the done state until that register is taken.
// Reset is asynchronous; memories read as zero until written (per-entry valid bits).
`include "fault_qualifier_bank_macros.svh"

module fault_qualifier_bank import fqb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fqb_req_if.sink           req,
	fqb_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W  = COUNT_BITS;
	localparam int RDC_W  = CH_W + 1;
	localparam int PROD_W = CNT_W + 1 + PER_W;
	localparam logic [RDC_W-1:0] LAST_RD = RDC_W'(FAULT_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PATH_FORCED,
		PATH_ACTIVE,
		PATH_RISE
	} path_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + CNT_W'(1);
	endfunction

	// configuration registers
	logic [MASK_W-1:0] enable_q;
	logic [MASK_W-1:0] override_q;
	logic [MAP_W-1:0]  crit_map_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= '1;
			override_q <= '0;
			crit_map_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ENABLE:   enable_q   <= pwdata[MASK_W-1:0];
				REG_OVERRIDE: override_q <= pwdata[MASK_W-1:0];
				REG_CRIT:     crit_map_q <= pwdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ENABLE:   prdata = APB_DW'(enable_q);
			REG_OVERRIDE: prdata = APB_DW'(override_q);
			REG_CRIT:     prdata = APB_DW'(crit_map_q);
			default:      prdata = '0;
		endcase
	end

	// sequencer state
	state_t            state_q;
	logic [RDC_W-1:0]  rd_cnt_q;
	logic [MASK_W-1:0] sig_mask_q;
	logic [MASK_W-1:0] active_q;
	logic [MASK_W-1:0] history_q;
	logic [MASK_W-1:0] rose_acc_q;
	logic [MASK_W-1:0] fell_acc_q;
	logic              warn_acc_q;
	logic              err_acc_q;
	logic              crit_acc_q;

	logic req_fire;
	logic issue;
	logic rsp_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign issue     = (state_q == ST_WALK) && (rd_cnt_q < LAST_RD);
	assign rsp_free  = !rsp.valid || rsp.ready;

	// memories and their valid bits
	thr_entry_t       thr_mem [FAULT_COUNT];
	logic [CNT_W-1:0] sig_mem [FAULT_COUNT];
	logic [CNT_W-1:0] tck_mem [FAULT_COUNT];
	logic [MASK_W-1:0] thr_vld_q;
	logic [MASK_W-1:0] cnt_vld_q;

	logic thr_wr;
	assign thr_wr = req_fire && (req.operation == OP_LOAD)
		&& (32'(req.entry_index) < 32'(FAULT_COUNT));

	// pipeline registers
	logic             vld_s1;
	logic [CH_W-1:0]  chan_s1;
	thr_entry_t       thr_rd_s1;
	logic [CNT_W-1:0] sig_rd_s1;
	logic [CNT_W-1:0] tck_rd_s1;

	logic              vld_s2;
	logic [CH_W-1:0]   chan_s2;
	path_t             path_s2;
	logic              fell_s2;
	logic [CNT_W-1:0]  sig_s2;
	logic [CNT_W-1:0]  tck_s2;
	logic [PROD_W-1:0] lim_s2;
	logic [PROD_W-1:0] tot_s2;
	logic [TH_W-1:0]   rise_ticks_s2;
	logic [TH_W-1:0]   rise_sig_s2;
	logic              per_nz_s2;
	logic [CRIT_W-1:0] crit_s2;

	always_ff @(posedge clk) begin
		if (thr_wr) begin
			thr_mem[req.entry_index] <= '{
				rise_ticks:   req.rise_ticks,
				rise_signals: req.rise_signals,
				fall_ticks:   req.fall_ticks,
				period_ms:    req.period_ms
			};
		end
		thr_rd_s1 <= thr_mem[rd_cnt_q[CH_W-1:0]];
	end

	logic [CNT_W-1:0] wr_sig;
	logic [CNT_W-1:0] wr_tck;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			sig_mem[chan_s2] <= wr_sig;
			tck_mem[chan_s2] <= wr_tck;
		end
		sig_rd_s1 <= sig_mem[rd_cnt_q[CH_W-1:0]];
		tck_rd_s1 <= tck_mem[rd_cnt_q[CH_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_vld_q <= '0;
			cnt_vld_q <= '0;
		end else begin
			if (thr_wr) begin
				thr_vld_q[req.entry_index] <= 1'b1;
			end
			if (vld_s2) begin
				cnt_vld_q[chan_s2] <= 1'b1;
			end
		end
	end

	// stage 1: counter update and rise-window products
	thr_entry_t        thr_c;
	logic [CNT_W-1:0]  sig_c;
	logic [CNT_W-1:0]  tck_c;
	logic              s_b;
	logic              en_b;
	logic              forced_b;
	logic [CNT_W-1:0]  tck_act;
	logic              fall_c;
	logic [CNT_W-1:0]  sig_i;
	logic [CNT_W-1:0]  tck_i;
	path_t             path_c;
	logic [CNT_W-1:0]  sig_n;
	logic [CNT_W-1:0]  tck_n;
	logic [PROD_W-1:0] lim_c;
	logic [PROD_W-1:0] tot_c;

	always_comb begin
		thr_c    = thr_vld_q[chan_s1] ? thr_rd_s1 : '0;
		sig_c    = cnt_vld_q[chan_s1] ? sig_rd_s1 : '0;
		tck_c    = cnt_vld_q[chan_s1] ? tck_rd_s1 : '0;
		s_b      = sig_mask_q[chan_s1];
		en_b     = enable_q[chan_s1];
		forced_b = override_q[chan_s1] && history_q[chan_s1] && en_b;

		tck_act = s_b ? '0 : sat_inc(tck_c);
		fall_c  = (thr_c.fall_ticks != '0) && (CNT_W'(thr_c.fall_ticks) <= tck_act);

		if (s_b && en_b) begin
			sig_i = sat_inc(sig_c);
			tck_i = sat_inc(tck_c);
		end else begin
			sig_i = sig_c;
			tck_i = (tck_c != '0) ? sat_inc(tck_c) : tck_c;
		end

		if (forced_b) begin
			path_c = PATH_FORCED;
			sig_n  = sig_c;
			tck_n  = tck_c;
		end else if (active_q[chan_s1]) begin
			path_c = PATH_ACTIVE;
			if (fall_c) begin
				sig_n = '0;
				tck_n = '0;
			end else begin
				sig_n = sig_c;
				tck_n = (thr_c.fall_ticks != '0) ? tck_act : tck_c;
			end
		end else begin
			path_c = PATH_RISE;
			sig_n  = sig_i;
			tck_n  = tck_i;
		end

		lim_c = PROD_W'({1'b0, sig_i} + (CNT_W+1)'(2)) * PROD_W'(thr_c.period_ms);
		tot_c = PROD_W'({1'b0, tck_i} + (CNT_W+1)'(1)) * PROD_W'(TICK_MS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		chan_s1       <= rd_cnt_q[CH_W-1:0];
		chan_s2       <= chan_s1;
		path_s2       <= path_c;
		fell_s2       <= (path_c == PATH_ACTIVE) && fall_c;
		sig_s2        <= sig_n;
		tck_s2        <= tck_n;
		lim_s2        <= lim_c;
		tot_s2        <= tot_c;
		rise_ticks_s2 <= thr_c.rise_ticks;
		rise_sig_s2   <= thr_c.rise_signals;
		per_nz_s2     <= (thr_c.period_ms != '0);
		crit_s2       <= crit_map_q[{chan_s1, 1'b0} +: CRIT_W];
	end

	// stage 2: sparse-signal drop, rise decision, write-back
	logic drop_s2;
	logic rise_s2;

	always_comb begin
		drop_s2 = (lim_s2 < tot_s2);
		rise_s2 = (path_s2 == PATH_RISE) && !drop_s2 && (sig_s2 != '0) && per_nz_s2
			&& (CNT_W'(rise_ticks_s2) <= tck_s2) && (CNT_W'(rise_sig_s2) <= sig_s2);
		if ((path_s2 == PATH_RISE) && (drop_s2 || rise_s2)) begin
			wr_sig = '0;
			wr_tck = '0;
		end else begin
			wr_sig = sig_s2;
			wr_tck = tck_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			rd_cnt_q           <= '0;
			sig_mask_q         <= '0;
			active_q           <= '0;
			history_q          <= '0;
			rose_acc_q         <= '0;
			fell_acc_q         <= '0;
			warn_acc_q         <= 1'b0;
			err_acc_q          <= 1'b0;
			crit_acc_q         <= 1'b0;
			rsp.valid          <= 1'b0;
			rsp.active_mask    <= '0;
			rsp.history_mask   <= '0;
			rsp.rose_mask      <= '0;
			rsp.fell_mask      <= '0;
			rsp.warning_event  <= 1'b0;
			rsp.error_event    <= 1'b0;
			rsp.critical_event <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && (state_q != ST_DONE)) begin
				rsp.valid <= 1'b0;
			end
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + RDC_W'(1);
			end
			if (vld_s2) begin
				if (path_s2 == PATH_FORCED) begin
					active_q[chan_s2] <= 1'b1;
				end
				if (fell_s2) begin
					active_q[chan_s2]   <= 1'b0;
					fell_acc_q[chan_s2] <= 1'b1;
				end
				if (rise_s2) begin
					active_q[chan_s2]   <= 1'b1;
					history_q[chan_s2]  <= 1'b1;
					rose_acc_q[chan_s2] <= 1'b1;
					case (crit_s2)
						CRIT_WARNING:  warn_acc_q <= 1'b1;
						CRIT_ERROR:    err_acc_q  <= 1'b1;
						CRIT_CRITICAL: crit_acc_q <= 1'b1;
						default: ;
					endcase
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						rose_acc_q <= '0;
						fell_acc_q <= '0;
						warn_acc_q <= 1'b0;
						err_acc_q  <= 1'b0;
						crit_acc_q <= 1'b0;
						sig_mask_q <= req.signal_mask;
						rd_cnt_q   <= '0;
						if (req.operation == OP_TICK) begin
							state_q <= ST_WALK;
						end else begin
							if (req.operation == OP_CLEAR) begin
								history_q <= '0;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (!issue && !vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp.valid          <= 1'b1;
						rsp.active_mask    <= active_q;
						rsp.history_mask   <= history_q;
						rsp.rose_mask      <= rose_acc_q;
						rsp.fell_mask      <= fell_acc_q;
						rsp.warning_event  <= warn_acc_q;
						rsp.error_event    <= err_acc_q;
						rsp.critical_event <= crit_acc_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FQB_ASSERT_NOW(a_pipe_in_walk, vld_s1 || vld_s2, state_q == ST_WALK, "channel in flight outside walk")
	`FQB_ASSERT_NOW(a_rose_fell_apart, 1'b1, (rose_acc_q & fell_acc_q) == '0, "channel both rose and fell")
	`FQB_ASSERT_NOW(a_rose_in_history, 1'b1, (rose_acc_q & ~history_q) == '0, "rose channel missing from history")
	`FQB_ASSERT_NEXT(a_clear_history, req_fire && (req.operation == OP_CLEAR), history_q == '0, "history not cleared")

endmodule
